// ===== hdl/rag_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the range query block.
package rag_pkg;

   localparam int DEPTH    = 1024;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int OPCODE_W = 3;
   localparam int INDEX_W  = 10;
   localparam int ELEM_W   = 16;
   localparam int BOUND_W  = 11;
   localparam int RESULT_W = 26;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = $clog2(DEPTH + 1);
   localparam int CMP_W    = (FILL_W > BOUND_W) ? FILL_W : BOUND_W;
   localparam int STEP_W   = $clog2(RESULT_W);

   localparam logic signed [RESULT_W-1:0] ELEM_MAX_VALUE = RESULT_W'(32767);
   localparam logic signed [RESULT_W-1:0] ELEM_MIN_VALUE = -RESULT_W'(32768);

   localparam logic [OPCODE_W-1:0] OP_LOAD = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SUM  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_AVG  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_MIN  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_MAX  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DIV0  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_WALK,
      S_DRAIN,
      S_DIV_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load_en;
      logic capture;
      logic init;
      logic walk;
      logic div_load;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic req_load;
      logic req_query;
      logic bad_range;
      logic empty;
      logic is_avg;
      logic last;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// ===== hdl/rag_ctrl.sv =====
// Controller state machine that sequences loads, range walks, division and result hand-off.
module rag_ctrl
   import rag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && sts.req_query) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (sts.bad_range || sts.empty) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = sts.is_avg ? S_DIV_LOAD : S_DONE;
         end
         S_DIV_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_en = req_valid && sts.req_load;
            cmd.capture = req_valid && sts.req_query;
         end
         S_START: begin
            cmd.init = 1'b1;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
         end
         S_DONE: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/rag_dp.sv =====
// Datapath: element memory, range pointer, accumulator, shift-subtract divider and result register.
module rag_dp
   import rag_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic [INDEX_W-1:0]         req_load_index,
   input  logic signed [ELEM_W-1:0]   req_load_value,
   input  logic [BOUND_W-1:0]         req_range_begin,
   input  logic [BOUND_W-1:0]         req_range_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]        rsp_status
);

   logic signed [ELEM_W-1:0]   mem [DEPTH];
   logic signed [ELEM_W-1:0]   rd_data_ff;
   logic                       mem_we;

   logic [OPCODE_W-1:0]        op_ff;
   logic [CMP_W-1:0]           begin_ff;
   logic [CMP_W-1:0]           end_ff;
   logic [CMP_W-1:0]           ptr_ff;
   logic [CMP_W-1:0]           div_ff;
   logic [CMP_W-1:0]           rem_ff;
   logic [RESULT_W-1:0]        quot_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       neg_ff;
   logic                       rd_valid_ff;
   logic signed [RESULT_W-1:0] acc_ff;
   logic [STATUS_W-1:0]        st_ff;
   logic signed [RESULT_W-1:0] res_value_ff;
   logic [STATUS_W-1:0]        res_status_ff;
   logic                       rsp_valid_ff;

   logic signed [RESULT_W-1:0] elem_ext;
   logic signed [RESULT_W-1:0] acc_in;
   logic [CMP_W:0]             rem_shift;
   logic                       rem_ge;
   logic signed [RESULT_W-1:0] final_value;

   assign mem_we = cmd.load_en && (CMP_W'(req_load_index) < CMP_W'(DEPTH));

   assign sts.req_load  = (req_opcode == OP_LOAD);
   assign sts.req_query = (req_opcode == OP_SUM) || (req_opcode == OP_AVG) ||
                          (req_opcode == OP_MIN) || (req_opcode == OP_MAX);
   assign sts.bad_range = (end_ff > CMP_W'(DEPTH)) || (begin_ff > end_ff);
   assign sts.empty     = (begin_ff == end_ff);
   assign sts.is_avg    = (op_ff == OP_AVG);
   assign sts.last      = ((ptr_ff + CMP_W'(1)) == end_ff);
   assign sts.div_done  = (step_ff == STEP_W'(RESULT_W - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ADDR_W'(req_load_index)] <= req_load_value;
      end
      rd_data_ff <= mem[ptr_ff[ADDR_W-1:0]];
   end

   assign elem_ext = RESULT_W'(rd_data_ff);

   always_comb begin
      acc_in = acc_ff;
      case (op_ff)
         OP_SUM, OP_AVG: begin
            acc_in = acc_ff + elem_ext;
         end
         OP_MIN: begin
            if (elem_ext < acc_ff) begin
               acc_in = elem_ext;
            end
         end
         OP_MAX: begin
            if (elem_ext > acc_ff) begin
               acc_in = elem_ext;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // One quotient bit per cycle; the remainder always stays below the divisor.
   assign rem_shift = {rem_ff, quot_ff[RESULT_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});

   assign final_value = (sts.is_avg && st_ff == STAT_OK) ?
                        (neg_ff ? -signed'(quot_ff) : signed'(quot_ff)) : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.walk;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         begin_ff <= CMP_W'(req_range_begin);
         end_ff   <= CMP_W'(req_range_end);
      end
      if (cmd.init) begin
         ptr_ff <= begin_ff;
         div_ff <= end_ff - begin_ff;
         if (sts.bad_range) begin
            st_ff  <= STAT_RANGE;
            acc_ff <= '0;
         end else if (sts.empty && sts.is_avg) begin
            st_ff  <= STAT_DIV0;
            acc_ff <= '0;
         end else begin
            st_ff <= STAT_OK;
            case (op_ff)
               OP_MIN:  acc_ff <= ELEM_MAX_VALUE;
               OP_MAX:  acc_ff <= ELEM_MIN_VALUE;
               default: acc_ff <= '0;
            endcase
         end
      end else if (rd_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.walk) begin
         ptr_ff <= ptr_ff + CMP_W'(1);
      end
      if (cmd.div_load) begin
         neg_ff  <= acc_ff[RESULT_W-1];
         quot_ff <= acc_ff[RESULT_W-1] ? RESULT_W'(-acc_ff) : RESULT_W'(acc_ff);
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[RESULT_W-2:0], rem_ge};
         rem_ff  <= rem_ge ? CMP_W'(rem_shift - {1'b0, div_ff}) : CMP_W'(rem_shift);
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.finish) begin
         res_value_ff  <= final_value;
         res_status_ff <= st_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_value_ff;
   assign rsp_status       = res_status_ff;

endmodule

// ===== hdl/range_aggregate_query.sv =====
// Top level of the range query block: element store with sum, average, minimum and maximum.
// Usage:
//   The req_ channel carries one item per handshake. Opcode load writes
//   req_load_value at req_load_index and gives no result. Opcodes sum, average,
//   minimum and maximum walk the half-open range
//   [req_range_begin, req_range_end) and give exactly one rsp_ item with
//   rsp_result_value and rsp_status. Other opcodes are dropped.
//   A query walks its range and reads the single memory port once per cycle;
//   an average then runs the one-bit-per-cycle divider. A bad or empty range
//   skips the walk and the divider.
//   One query is in flight at a time. The result sits in an output register,
//   so while the receiver stalls the block returns to idle and keeps taking
//   loads and a next query; that query waits at its end until the register
//   is free. Reset is synchronous and clears the controller and the response
//   valid flag; the element store keeps its contents and is undefined until
//   loaded, and queries must touch only loaded entries.
module range_aggregate_query
   import rag_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic [INDEX_W-1:0]         req_load_index,
   input  logic signed [ELEM_W-1:0]   req_load_value,
   input  logic [BOUND_W-1:0]         req_range_begin,
   input  logic [BOUND_W-1:0]         req_range_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]        rsp_status
);

   cmd_type cmd;
   sts_type sts;

   rag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rag_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_load_index   (req_load_index),
      .req_load_value   (req_load_value),
      .req_range_begin  (req_range_begin),
      .req_range_end    (req_range_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== hdl/rag_checker.sv =====
// Port-level checker for the range query block, bound to the top level.
module rag_checker
   import rag_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [RESULT_W-1:0] rsp_result_value,
   input logic [STATUS_W-1:0]        rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_status))
      else $error("response item changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_result_value == '0)
      else $error("error status with non-zero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_DIV0 ||
                    rsp_status == STAT_RANGE)
      else $error("undefined status code");

endmodule

bind range_aggregate_query rag_checker u_rag_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);

// ===== tb/range_aggregate_query_checker.sv =====
`timescale 1ns / 1ps
// Checker for the range query block: mirrors the element store, predicts every result and compares.
module range_aggregate_query_checker
   import rag_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic [INDEX_W-1:0]         req_load_index,
   input  logic signed [ELEM_W-1:0]   req_load_value,
   input  logic [BOUND_W-1:0]         req_range_begin,
   input  logic [BOUND_W-1:0]         req_range_end,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [RESULT_W-1:0] rsp_result_value,
   input  logic [STATUS_W-1:0]        rsp_status,
   output int                         mismatch_count,
   output int                         awaited_count,
   output int                         answered_count
);

   typedef struct packed {
      logic signed [RESULT_W-1:0] value;
      logic [STATUS_W-1:0]        status;
   } aggregate_type;

   logic signed [ELEM_W-1:0] shadow_store [DEPTH];
   aggregate_type            pending_results [$];
   aggregate_type            oldest;
   int                       mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // Sum, average, minimum or maximum over [first, past) of the mirrored store.
   function automatic aggregate_type aggregate_range(input logic [OPCODE_W-1:0] op,
                                                     input logic [BOUND_W-1:0] first,
                                                     input logic [BOUND_W-1:0] past);
      aggregate_type res;
      longint        acc;
      int            span;
      int            i;
      res.status = STAT_OK;
      acc = 0;
      span = past - first;
      if (past > DEPTH || first > past) begin
         res.status = STAT_RANGE;
      end else if (op == OP_SUM || op == OP_AVG) begin
         for (i = first; i < past; i++) acc += shadow_store[i];
         if (op == OP_AVG) begin
            if (span == 0) begin
               res.status = STAT_DIV0;
               acc = 0;
            end else begin
               // Signed division here truncates toward zero, as the block must.
               acc = acc / span;
            end
         end
      end else if (op == OP_MIN) begin
         acc = ELEM_MAX_VALUE;
         for (i = first; i < past; i++) if (shadow_store[i] < acc) acc = shadow_store[i];
      end else begin
         acc = ELEM_MIN_VALUE;
         for (i = first; i < past; i++) if (shadow_store[i] > acc) acc = shadow_store[i];
      end
      res.value = acc[RESULT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_results.delete();
         awaited_count  <= 0;
         answered_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_opcode == OP_LOAD) begin
               shadow_store[req_load_index] = req_load_value;
            end else if (req_opcode <= OP_MAX) begin
               pending_results.push_back(aggregate_range(req_opcode, req_range_begin,
                                                         req_range_end));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with no query waiting: value %0d status %0d",
                                         rsp_result_value, rsp_status));
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_result_value !== oldest.value || rsp_status !== oldest.status) begin
                  report_mismatch($sformatf("value %0d status %0d, wanted value %0d status %0d",
                                            rsp_result_value, rsp_status,
                                            oldest.value, oldest.status));
               end
               answered_count <= answered_count + 1;
            end
         end
         awaited_count <= pending_results.size();
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the range query testbench: clock, reset, item stimulus and the final verdict.
module tb
   import rag_pkg::*;
();

   localparam int TOTAL_ITEMS = 560;
   localparam int QUIET_ITEMS = 60;
   localparam int DRAIN_EVERY = 140;
   localparam int TAIL_CYCLES = 48;
   localparam int TIMEOUT_NS  = 10_000_000;
   localparam int OPCODE_TOP  = (1 << OPCODE_W) - 1;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [OPCODE_W-1:0]        req_opcode;
   logic [INDEX_W-1:0]         req_load_index;
   logic signed [ELEM_W-1:0]   req_load_value;
   logic [BOUND_W-1:0]         req_range_begin;
   logic [BOUND_W-1:0]         req_range_end;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [RESULT_W-1:0] rsp_result_value;
   logic [STATUS_W-1:0]        rsp_status;

   int mismatch_count;
   int awaited_count;
   int answered_count;

   // Entries loaded so far; queries only ever walk over these.
   bit written [DEPTH];
   bit quiet = 1'b0;
   bit calm  = 1'b0;
   int sent_items = 0;
   int n_loads    = 0;
   int n_queries  = 0;
   int n_dropped  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   range_aggregate_query u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_load_index   (req_load_index),
      .req_load_value   (req_load_value),
      .req_range_begin  (req_range_begin),
      .req_range_end    (req_range_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   range_aggregate_query_checker u_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_load_index   (req_load_index),
      .req_load_value   (req_load_value),
      .req_range_begin  (req_range_begin),
      .req_range_end    (req_range_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .mismatch_count   (mismatch_count),
      .awaited_count    (awaited_count),
      .answered_count   (answered_count)
   );

   // Presents one item, possibly after a burst of idle cycles, and returns at the
   // edge at which it is accepted.
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic signed [ELEM_W-1:0] val,
                            input logic [BOUND_W-1:0] first, input logic [BOUND_W-1:0] past);
      int gap;
      gap = 0;
      quiet = sent_items >= TOTAL_ITEMS - QUIET_ITEMS;
      calm  = (sent_items / 50) % 5 == 2;
      if (!quiet && !calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_load_index  <= idx;
      req_load_value  <= val;
      req_range_begin <= first;
      req_range_end   <= past;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD) begin
         written[idx] = 1'b1;
         n_loads++;
         sent_items++;
      end else if (op <= OP_MAX) begin
         n_queries++;
         sent_items++;
      end else begin
         n_dropped++;
      end
   endtask

   // Holds the sender off until every outstanding result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (awaited_count == 0);
      @(posedge clock);
   endtask

   function automatic logic signed [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int                 kind;
      int                 base;
      int                 len;
      int                 start;
      int                 stop;
      int                 lim;
      int                 k;
      int                 next_drain;
      logic [BOUND_W-1:0] first;
      logic [BOUND_W-1:0] past;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= OP_LOAD;
      req_load_index  <= '0;
      req_load_value  <= '0;
      req_range_begin <= '0;
      req_range_end   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extreme values at both ends of the store, then every operation.
      send_item(OP_LOAD, 10'd0, 16'sh8000, 11'h7FF, 11'h7FF);
      send_item(OP_LOAD, 10'd1, 16'sh7FFF, 11'h000, 11'h7FF);
      send_item(OP_LOAD, 10'd2, 16'sh0000, 11'h7FF, 11'h000);
      send_item(OP_LOAD, 10'd3, -16'sd1, 11'h000, 11'h000);
      send_item(OP_LOAD, 10'd1023, 16'sh7FFF, 11'h7FF, 11'h7FF);
      send_item(OP_LOAD, 10'd1022, 16'sh8000, 11'h000, 11'h000);
      send_item(OP_LOAD, 10'd1021, 16'sd1, 11'h000, 11'h000);
      send_item(OP_SUM, 10'd0, 16'sd0, 11'd0, 11'd4);
      // A negative sum that does not divide evenly must round toward zero.
      send_item(OP_AVG, 10'h3FF, 16'sh7FFF, 11'd0, 11'd4);
      send_item(OP_AVG, 10'd0, 16'sd0, 11'd3, 11'd4);
      send_item(OP_AVG, 10'd0, 16'sd0, 11'd0, 11'd1);
      send_item(OP_MIN, 10'd0, 16'sd0, 11'd0, 11'd4);
      send_item(OP_MAX, 10'd0, 16'sd0, 11'd0, 11'd4);
      send_item(OP_SUM, 10'd0, 16'sd0, 11'd1021, 11'd1024);
      send_item(OP_MIN, 10'd0, 16'sd0, 11'd1022, 11'd1024);
      send_item(OP_MAX, 10'd0, 16'sd0, 11'd1021, 11'd1024);
      // Empty ranges: the average reports division by zero, the rest their start values.
      send_item(OP_AVG, 10'd0, 16'sd0, 11'd1024, 11'd1024);
      send_item(OP_SUM, 10'd0, 16'sd0, 11'd5, 11'd5);
      send_item(OP_MIN, 10'd0, 16'sd0, 11'd1024, 11'd1024);
      send_item(OP_MAX, 10'd0, 16'sd0, 11'd0, 11'd0);
      // Ranges past the end of the store or reversed.
      send_item(OP_SUM, 10'd0, 16'sd0, 11'd0, 11'd1025);
      send_item(OP_AVG, 10'd0, 16'sd0, 11'd0, 11'h7FF);
      send_item(OP_MIN, 10'd0, 16'sd0, 11'd4, 11'd3);
      send_item(OP_MAX, 10'd0, 16'sd0, 11'h7FF, 11'd1024);
      for (k = OP_MAX + 1; k <= OPCODE_TOP; k++) begin
         send_item(OPCODE_W'(k), 10'h3FF, 16'shFFFF, 11'd0, 11'd4);
      end
      drain_results();

      next_drain = sent_items + DRAIN_EVERY;
      while (sent_items < TOTAL_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            base = $urandom_range(0, DEPTH - 1);
            len  = $urandom_range(1, 8);
            for (k = 0; k < len && base + k < DEPTH; k++) begin
               send_item(OP_LOAD, INDEX_W'(base + k), pick_element(),
                         BOUND_W'($urandom), BOUND_W'($urandom));
            end
         end else if (kind < 70) begin
            // A range that starts on a loaded entry and stays within the loaded run.
            start = $urandom_range(0, DEPTH - 1);
            for (k = 0; k < DEPTH && !written[start]; k++) start = (start + 1) % DEPTH;
            lim  = ($urandom_range(0, 29) == 0) ? DEPTH : $urandom_range(1, 20);
            stop = start;
            while (stop < DEPTH && written[stop] && stop - start < lim) stop++;
            send_item(OPCODE_W'($urandom_range(OP_SUM, OP_MAX)), INDEX_W'($urandom),
                      ELEM_W'($urandom), BOUND_W'(start),
                      BOUND_W'($urandom_range(start, stop)));
         end else if (kind < 78) begin
            first = BOUND_W'($urandom_range(0, DEPTH));
            send_item(OPCODE_W'($urandom_range(OP_SUM, OP_MAX)), INDEX_W'($urandom),
                      ELEM_W'($urandom), first, first);
         end else if (kind < 88) begin
            if ($urandom_range(0, 1) == 0) begin
               past  = BOUND_W'($urandom_range(DEPTH + 1, (1 << BOUND_W) - 1));
               first = BOUND_W'($urandom);
            end else begin
               past  = BOUND_W'($urandom_range(0, DEPTH - 1));
               first = BOUND_W'($urandom_range(past + 1, (1 << BOUND_W) - 1));
            end
            send_item(OPCODE_W'($urandom_range(OP_SUM, OP_MAX)), INDEX_W'($urandom),
                      ELEM_W'($urandom), first, past);
         end else if (kind < 93) begin
            send_item(OPCODE_W'($urandom_range(OP_MAX + 1, OPCODE_TOP)), INDEX_W'($urandom),
                      ELEM_W'($urandom), BOUND_W'($urandom), BOUND_W'($urandom));
         end else begin
            send_item(OP_LOAD, INDEX_W'($urandom), ELEM_W'($urandom),
                      BOUND_W'($urandom), BOUND_W'($urandom));
         end
         if (sent_items >= next_drain) begin
            drain_results();
            next_drain += DRAIN_EVERY;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d loads, %0d queries and %0d items with unused opcodes.",
               n_loads, n_queries, n_dropped);
      $display("%0d results were checked; %0d did not match.", answered_count, mismatch_count);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("range_aggregate_query test passed");
      end else begin
         $display("range_aggregate_query test failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d results still awaited.", awaited_count);
      $display("range_aggregate_query test failed");
      $finish;
   end

endmodule
